// ----- src/icr_pkg.sv -----
// Shared types, constants and checksum helpers for the ICMP receive checker.
// Depends on nothing; every other file in src imports it.
package icr_pkg;

    // Default width of the saturating byte counter.
    localparam int DEF_LENGTH_BITS = 16;

    // Width of the reported message length and of one checksum word.
    localparam int LEN_W  = 16;
    localparam int WORD_W = 16;

    // Depth of the record queue between the front and the back.
    localparam int QDEPTH = 2;

    // Header layout: byte positions where each header word completes.
    localparam int HDR_LEN    = 8;
    localparam int POS_FIRST  = 1;
    localparam int POS_CSUM   = 3;
    localparam int POS_ID     = 5;
    localparam int POS_SEQ    = 7;
    localparam int BODY_START = 4;

    // ICMP type codes that get a class of their own.
    localparam logic [7:0] T_ECHO_REPLY    = 8'd0;
    localparam logic [7:0] T_UNREACH       = 8'd3;
    localparam logic [7:0] T_ECHO_REQ      = 8'd8;
    localparam logic [7:0] T_TIME_EXCEEDED = 8'd11;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_SHORT      = 3'd0,
        ST_BAD_CSUM   = 3'd1,
        ST_ECHO_REQ   = 3'd2,
        ST_ECHO_REPLY = 3'd3,
        ST_UNREACH    = 3'd4,
        ST_TIME_EXC   = 3'd5,
        ST_OTHER      = 3'd6
    } t_status;

    // One finished message as handed from the front to the back.
    typedef struct packed {
        logic [WORD_W-1:0] first_word;
        logic [WORD_W-1:0] rcv_sum;
        logic [WORD_W-1:0] id_word;
        logic [WORD_W-1:0] seq_word;
        logic [WORD_W:0]   body_sum;
        logic [LEN_W-1:0]  length;
    } t_msg_rec;

    // One's-complement add of a word into a folded sum (sum stays <= 0x10000).
    function automatic logic [WORD_W:0] fold_add(input logic [WORD_W:0] s,
                                                 input logic [WORD_W-1:0] w);
        logic [WORD_W:0] t;
        t = s + {1'b0, w};
        return {1'b0, t[WORD_W-1:0]} + {{WORD_W{1'b0}}, t[WORD_W]};
    endfunction

    // Final fold of a sum that is at most 0x10000 down to one word.
    function automatic logic [WORD_W-1:0] fold_final(input logic [WORD_W:0] s);
        return s[WORD_W-1:0] | {{(WORD_W-1){1'b0}}, s[WORD_W]};
    endfunction

endpackage

// ----- src/icmp_receive_checker.sv -----
// Top level of the ICMP receive checker: byte front end, record queue and
// result back end. Depends on icr_pkg, icr_front, icr_queue and icr_back.
//
//   Channel   Handshake          Words carried
//   -------   ----------------   ------------------------------------------
//   input     push / full        one message byte plus its last-byte mark
//   result    empty / pop        status and header fields of one message
//
// One byte is taken every cycle while full is low; the front adds at most one word
// into the sum per byte. A result passes through the record queue and the result
// register before it shows on the ports. full rises only when two finished messages
// wait in the queue behind an unread result. Reset is synchronous and active low.
module icmp_receive_checker import icr_pkg::*; #(
    parameter int LENGTH_BITS = DEF_LENGTH_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_status,
    output logic [7:0]  o_msg_type,
    output logic [7:0]  o_msg_code,
    output logic [15:0] o_echo_id,
    output logic [15:0] o_echo_seq,
    output logic [15:0] o_reply_checksum,
    output logic [15:0] o_packet_length
);

    logic     accept;
    logic     q_push;
    t_msg_rec q_in_rec;
    logic     q_valid;
    t_msg_rec q_out_rec;
    logic     q_pop;

    assign accept = push && !full;

    // Byte intake and running sum.
    icr_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_push      (q_push),
        .o_rec       (q_in_rec)
    );

    // Finished message records.
    icr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_rec   (q_in_rec),
        .i_pop   (q_pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_rec   (q_out_rec)
    );

    // Checksum finish, classification and result register.
    icr_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (q_valid),
        .i_rec            (q_out_rec),
        .o_take           (q_pop),
        .i_pop            (pop),
        .o_empty          (empty),
        .o_status         (o_status),
        .o_msg_type       (o_msg_type),
        .o_msg_code       (o_msg_code),
        .o_echo_id        (o_echo_id),
        .o_echo_seq       (o_echo_seq),
        .o_reply_checksum (o_reply_checksum),
        .o_packet_length  (o_packet_length)
    );

endmodule

// ----- src/icr_front.sv -----
// Front end of the ICMP receive checker: takes bytes, pairs them into words,
// captures the header words and keeps the running body sum. Uses icr_pkg.
module icr_front import icr_pkg::*; #(
    parameter int LENGTH_BITS = DEF_LENGTH_BITS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_data_byte,
    input  logic           i_last_byte,
    output logic           o_push,
    output t_msg_rec       o_rec
);

    logic [LENGTH_BITS-1:0] r_count, n_count;
    logic                   r_phase;
    logic [WORD_W:0]        r_body, n_body;
    logic [7:0]             r_high, n_high;
    logic [WORD_W-1:0]      r_first, n_first;
    logic [WORD_W-1:0]      r_rcv, n_rcv;
    logic [WORD_W-1:0]      r_id, n_id;
    logic [WORD_W-1:0]      r_seq, n_seq;
    logic [WORD_W-1:0]      w;

    // Word assembly and one sum step for the current byte.
    always_comb begin
        w       = {r_high, i_data_byte};
        n_high  = r_high;
        n_first = r_first;
        n_rcv   = r_rcv;
        n_id    = r_id;
        n_seq   = r_seq;
        n_body  = r_body;
        if (!r_phase) begin
            n_high = i_data_byte;
            // An odd final byte is the high half of a zero-padded word.
            if (i_last_byte && r_count >= LENGTH_BITS'(HDR_LEN)) begin
                n_body = fold_add(r_body, {i_data_byte, 8'h00});
            end
        end else begin
            if (r_count == LENGTH_BITS'(POS_FIRST)) begin
                n_first = w;
            end else if (r_count == LENGTH_BITS'(POS_CSUM)) begin
                n_rcv = w;
            end else if (r_count == LENGTH_BITS'(POS_ID)) begin
                n_id = w;
            end else if (r_count == LENGTH_BITS'(POS_SEQ)) begin
                n_seq = w;
            end
            if (r_count >= LENGTH_BITS'(BODY_START)) begin
                n_body = fold_add(r_body, w);
            end
        end
        n_count = (r_count == '1) ? r_count : r_count + 1'b1;
    end

    // The record leaves with the values that include the final byte.
    assign o_push           = i_accept & i_last_byte;
    assign o_rec.first_word = n_first;
    assign o_rec.rcv_sum    = n_rcv;
    assign o_rec.id_word    = n_id;
    assign o_rec.seq_word   = n_seq;
    assign o_rec.body_sum   = n_body;
    assign o_rec.length     = LEN_W'(n_count);

    // Control state: counter, word phase and sum restart after each message.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_phase <= 1'b0;
            r_body  <= '0;
        end else if (i_accept) begin
            if (i_last_byte) begin
                r_count <= '0;
                r_phase <= 1'b0;
                r_body  <= '0;
            end else begin
                r_count <= n_count;
                r_phase <= ~r_phase;
                r_body  <= n_body;
            end
        end
    end

    // Header words are only read once the message is long enough to hold them.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_high  <= n_high;
            r_first <= n_first;
            r_rcv   <= n_rcv;
            r_id    <= n_id;
            r_seq   <= n_seq;
        end
    end

endmodule

// ----- src/icr_queue.sv -----
// Short record queue between the front and the back of the checker.
// Uses icr_pkg for the record type and the queue depth.
module icr_queue import icr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_msg_rec i_rec,
    input  logic     i_pop,
    output logic     o_full,
    output logic     o_valid,
    output t_msg_rec o_rec
);

    localparam int PtrW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CntW = $clog2(QDEPTH + 1);

    t_msg_rec            r_mem [QDEPTH];
    logic [PtrW-1:0]     r_wr_ptr;
    logic [PtrW-1:0]     r_rd_ptr;
    logic [CntW-1:0]     r_count;

    assign o_full  = (r_count == CntW'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rd_ptr];

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTH
    // The fill count never passes the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(QDEPTH))
        else $error("record queue count beyond depth");

    // Writes to a full queue come only with a read; no read when empty.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop) && !(i_pop && !o_valid))
        else $error("record queue overflow or underflow");

    // A lone read of the last record leaves the queue empty.
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !i_push && r_count == CntW'(1)) |=> !o_valid)
        else $error("record queue did not drain");
`endif

endmodule

// ----- src/icr_back.sv -----
// Back end of the ICMP receive checker: finishes the checksum, classifies
// the message and holds the result word for the reader. Uses icr_pkg.
module icr_back import icr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_msg_rec    i_rec,
    output logic        o_take,
    input  logic        i_pop,
    output logic        o_empty,
    output logic [2:0]  o_status,
    output logic [7:0]  o_msg_type,
    output logic [7:0]  o_msg_code,
    output logic [15:0] o_echo_id,
    output logic [15:0] o_echo_seq,
    output logic [15:0] o_reply_checksum,
    output logic [15:0] o_packet_length
);

    logic              r_out_valid;
    t_status           r_status, n_status;
    logic [7:0]        r_msg_type, n_msg_type;
    logic [7:0]        r_msg_code, n_msg_code;
    logic [15:0]       r_echo_id, n_echo_id;
    logic [15:0]       r_echo_seq, n_echo_seq;
    logic [15:0]       r_reply_sum, n_reply_sum;
    logic [15:0]       r_length;
    logic [WORD_W:0]   all_sum;
    logic [WORD_W-1:0] calc_sum;
    logic              short_msg;

    // A record moves on when the output slot is free or being read.
    assign o_take = i_valid && (!r_out_valid || i_pop);

    // Checksum finish and message class.
    always_comb begin
        all_sum     = fold_add(i_rec.body_sum, i_rec.first_word);
        calc_sum    = ~fold_final(all_sum);
        short_msg   = (i_rec.length < LEN_W'(HDR_LEN));
        n_msg_type  = i_rec.first_word[15:8];
        n_msg_code  = i_rec.first_word[7:0];
        n_echo_id   = i_rec.id_word;
        n_echo_seq  = i_rec.seq_word;
        n_reply_sum = ~fold_final(i_rec.body_sum);
        if (short_msg) begin
            n_status    = ST_SHORT;
            n_msg_type  = '0;
            n_msg_code  = '0;
            n_echo_id   = '0;
            n_echo_seq  = '0;
            n_reply_sum = '0;
        end else if (calc_sum != i_rec.rcv_sum) begin
            n_status = ST_BAD_CSUM;
        end else begin
            case (n_msg_type)
                T_ECHO_REQ:      n_status = ST_ECHO_REQ;
                T_ECHO_REPLY:    n_status = ST_ECHO_REPLY;
                T_UNREACH:       n_status = ST_UNREACH;
                T_TIME_EXCEEDED: n_status = ST_TIME_EXC;
                default:         n_status = ST_OTHER;
            endcase
        end
    end

    // Output slot valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result word registers.
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_status    <= n_status;
            r_msg_type  <= n_msg_type;
            r_msg_code  <= n_msg_code;
            r_echo_id   <= n_echo_id;
            r_echo_seq  <= n_echo_seq;
            r_reply_sum <= n_reply_sum;
            r_length    <= i_rec.length;
        end
    end

    assign o_empty          = !r_out_valid;
    assign o_status         = r_status;
    assign o_msg_type       = r_msg_type;
    assign o_msg_code       = r_msg_code;
    assign o_echo_id        = r_echo_id;
    assign o_echo_seq       = r_echo_seq;
    assign o_reply_checksum = r_reply_sum;
    assign o_packet_length  = r_length;

`ifndef SYNTH
    // A short message reports no header fields.
    a_short_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_SHORT) |->
        (r_msg_type == 8'd0 && r_echo_id == 16'd0 && r_reply_sum == 16'd0))
        else $error("short message carries header fields");

    // A waiting result word is neither lost nor replaced while unread.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_pop) |=> (r_out_valid && $stable(r_length)
        && $stable(r_status)))
        else $error("unread result word changed");

    // A short class goes only with a length under the header size.
    a_short_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_status == ST_SHORT) == (r_length < LEN_W'(HDR_LEN))))
        else $error("short status disagrees with length");
`endif

endmodule
